### src/cshe_pkg.sv
// Shared types and constants of the CBOR scalar head encoder.
package cshe_pkg;

	// Input modes
	localparam logic [2:0] MODE_HEAD   = 3'd0;
	localparam logic [2:0] MODE_SINT   = 3'd1;
	localparam logic [2:0] MODE_F64    = 3'd2;
	localparam logic [2:0] MODE_BOOL   = 3'd3;
	localparam logic [2:0] MODE_NULL   = 3'd4;
	localparam logic [2:0] MODE_UNDEF  = 3'd5;
	localparam logic [2:0] MODE_SIMPLE = 3'd6;
	localparam logic [2:0] MODE_RSVD   = 3'd7;

	// Additional-information codes and fixed bytes
	localparam logic [4:0] AI_1BYTE     = 5'd24;
	localparam logic [4:0] AI_2BYTE     = 5'd25;
	localparam logic [4:0] AI_4BYTE     = 5'd26;
	localparam logic [4:0] AI_8BYTE     = 5'd27;
	localparam logic [2:0] MAJOR_UINT   = 3'd0;
	localparam logic [2:0] MAJOR_NINT   = 3'd1;
	localparam logic [7:0] BYTE_HALF    = 8'hF9;
	localparam logic [7:0] BYTE_DOUBLE  = 8'hFB;
	localparam logic [7:0] BYTE_TRUE    = 8'hF5;
	localparam logic [7:0] BYTE_FALSE   = 8'hF4;
	localparam logic [7:0] BYTE_NULL    = 8'hF6;
	localparam logic [7:0] BYTE_UNDEF   = 8'hF7;
	localparam logic [7:0] BYTE_SIMPLE8 = 8'hF8;
	localparam logic [7:0] HALF_NAN_HI  = 8'h7E;
	localparam logic [7:0] HALF_PINF_HI = 8'h7C;
	localparam logic [7:0] HALF_NINF_HI = 8'hFC;
	localparam logic [2:0] MAJOR_SIMPLE = 3'd7;
	localparam logic [7:0] SIMPLE_LIMIT = 8'd20;

	// Descriptor queue
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// One encoded item: initial byte plus cnt trailing bytes, left-aligned in data
	typedef struct packed {
		logic [7:0]  head;
		logic [3:0]  cnt;
		logic [63:0] data;
	} cshe_desc_t;

endpackage

### src/cshe_in_if.sv
// Input channel: one scalar item per word.
interface cshe_in_if;
	logic        valid;
	logic        ready;
	logic [2:0]  mode;
	logic [2:0]  major_type;
	logic [63:0] value;

	modport source (output valid, output mode, output major_type, output value, input ready);
	modport sink   (input valid, input mode, input major_type, input value, output ready);
endinterface

### src/cshe_out_if.sv
// Output channel: one encoded byte per word.
interface cshe_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last;

	modport source (output valid, output out_byte, output last, input ready);
	modport sink   (input valid, input out_byte, input last, output ready);
endinterface

### src/cbor_scalar_head_encoder_core.sv
// CBOR scalar head encoder top level: front end, descriptor queue, byte serializer.
// Each accepted word is one scalar CBOR item; the block emits its encoding one byte
// per output word, most significant first, with last set on the final byte. An item
// has 1 to 9 bytes. Unless the output is stalled, the byte serializer takes the
// next item's initial byte from the queue head once the previous item's final byte
// is registered. When the path is empty, the first byte of a word passes through
// the front-end register, the descriptor queue and the output register before it
// is offered on the output. A four-deep descriptor queue sits between front and
// back, so input words keep being taken while the output is stalled until the
// queue fills. Mode 7 is accepted and produces no bytes.
module cbor_scalar_head_encoder_core (
	input  logic        clk,
	input  logic        arst_n,
	cshe_in_if.sink     in_ch,
	cshe_out_if.source  out_ch
);
	import cshe_pkg::*;

	logic       push_valid;
	logic       push_ready;
	cshe_desc_t push_desc;
	logic       pop_valid;
	logic       pop_ready;
	cshe_desc_t pop_desc;

	cshe_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ch      (in_ch),
		.push_valid (push_valid),
		.push_desc  (push_desc),
		.push_ready (push_ready)
	);

	cshe_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_desc  (push_desc),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_desc   (pop_desc),
		.pop_ready  (pop_ready)
	);

	cshe_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (pop_valid),
		.q_desc  (pop_desc),
		.q_ready (pop_ready),
		.out_ch  (out_ch)
	);

endmodule

### src/cshe_front.sv
// Front end: accepts items, classifies them and builds byte descriptors.
module cshe_front (
	input  logic                clk,
	input  logic                arst_n,
	cshe_in_if.sink             in_ch,
	output logic                push_valid,
	output cshe_pkg::cshe_desc_t push_desc,
	input  logic                push_ready
);
	import cshe_pkg::*;

	logic       valid_s1;
	cshe_desc_t desc_s1;
	cshe_desc_t desc;
	logic       accept;

	function automatic cshe_desc_t head_desc(input logic [2:0] major, input logic [63:0] arg);
		cshe_desc_t d;
		d.data = '0;
		if (arg < 64'd24) begin
			d.head = {major, arg[4:0]};
			d.cnt  = 4'd0;
		end else if (arg[63:8] == '0) begin
			d.head = {major, AI_1BYTE};
			d.cnt  = 4'd1;
			d.data = {arg[7:0], 56'd0};
		end else if (arg[63:16] == '0) begin
			d.head = {major, AI_2BYTE};
			d.cnt  = 4'd2;
			d.data = {arg[15:0], 48'd0};
		end else if (arg[63:32] == '0) begin
			d.head = {major, AI_4BYTE};
			d.cnt  = 4'd4;
			d.data = {arg[31:0], 32'd0};
		end else begin
			d.head = {major, AI_8BYTE};
			d.cnt  = 4'd8;
			d.data = arg;
		end
		return d;
	endfunction

	always_comb begin
		desc = '0;
		case (in_ch.mode)
			MODE_HEAD: desc = head_desc(in_ch.major_type, in_ch.value);
			MODE_SINT: begin
				// negative: major 1 with the complement as argument
				if (in_ch.value[63])
					desc = head_desc(MAJOR_NINT, ~in_ch.value);
				else
					desc = head_desc(MAJOR_UINT, in_ch.value);
			end
			MODE_F64: begin
				if (in_ch.value[62:52] == 11'h7FF) begin
					desc.head = BYTE_HALF;
					desc.cnt  = 4'd2;
					if (in_ch.value[51:0] != '0)
						desc.data = {HALF_NAN_HI, 56'd0};
					else if (in_ch.value[63])
						desc.data = {HALF_NINF_HI, 56'd0};
					else
						desc.data = {HALF_PINF_HI, 56'd0};
				end else begin
					desc.head = BYTE_DOUBLE;
					desc.cnt  = 4'd8;
					desc.data = in_ch.value;
				end
			end
			MODE_BOOL:  desc.head = in_ch.value[0] ? BYTE_TRUE : BYTE_FALSE;
			MODE_NULL:  desc.head = BYTE_NULL;
			MODE_UNDEF: desc.head = BYTE_UNDEF;
			MODE_SIMPLE: begin
				if (in_ch.value[7:0] < SIMPLE_LIMIT) begin
					desc.head = {MAJOR_SIMPLE, in_ch.value[4:0]};
				end else begin
					desc.head = BYTE_SIMPLE8;
					desc.cnt  = 4'd1;
					desc.data = {in_ch.value[7:0], 56'd0};
				end
			end
			default: desc = '0;
		endcase
	end

	assign in_ch.ready = !valid_s1 || push_ready;
	assign accept      = in_ch.valid && in_ch.ready;
	assign push_valid  = valid_s1;
	assign push_desc   = desc_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			// reserved mode is dropped here
			valid_s1 <= (in_ch.mode != MODE_RSVD);
		end else if (push_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			desc_s1 <= desc;
		end
	end

endmodule

### src/cshe_queue.sv
// Short descriptor queue between front and back end.
module cshe_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push_valid,
	input  cshe_pkg::cshe_desc_t push_desc,
	output logic                 push_ready,
	output logic                 pop_valid,
	output cshe_pkg::cshe_desc_t pop_desc,
	input  logic                 pop_ready
);
	import cshe_pkg::*;

	cshe_desc_t          mem [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;
	logic                push;
	logic                pop;

	assign push_ready = (count_q != QCNT_W'(QDEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_desc   = mem[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_desc;
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QDEPTH))
		else $error("queue count out of range");

	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count missed a push");

	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != '0 && count_q != QCNT_W'(QDEPTH)) |->
		(wr_ptr_q != rd_ptr_q))
		else $error("queue pointers disagree with count");

endmodule

### src/cshe_back.sv
// Back end: serializes descriptors into bytes through an output register.
module cshe_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_valid,
	input  cshe_pkg::cshe_desc_t q_desc,
	output logic                 q_ready,
	cshe_out_if.source           out_ch
);
	import cshe_pkg::*;

	logic        busy_q;
	logic [3:0]  cnt_q;
	logic [63:0] data_q;
	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic        last_q;
	logic        advance;
	logic        emit;
	logic [7:0]  emit_byte;
	logic        emit_last;

	assign advance = !out_valid_q || out_ch.ready;
	// initial byte goes straight from the queue head; trailing bytes from data_q
	assign q_ready = advance && !busy_q;
	assign emit    = advance && (busy_q || q_valid);

	always_comb begin
		if (busy_q) begin
			emit_byte = data_q[63:56];
			emit_last = (cnt_q == 4'd1);
		end else begin
			emit_byte = q_desc.head;
			emit_last = (q_desc.cnt == 4'd0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance)
				out_valid_q <= emit;
			if (emit) begin
				busy_q <= !emit_last;
				if (busy_q)
					cnt_q <= cnt_q - 4'd1;
				else
					cnt_q <= q_desc.cnt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q <= emit_byte;
			last_q     <= emit_last;
			if (busy_q)
				data_q <= {data_q[55:0], 8'd0};
			else
				data_q <= q_desc.data;
		end
	end

	assign out_ch.valid    = out_valid_q;
	assign out_ch.out_byte = out_byte_q;
	assign out_ch.last     = last_q;

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (cnt_q != 4'd0 && cnt_q <= 4'd8))
		else $error("byte count out of range while busy");

	a_tail_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !last_q) |-> busy_q)
		else $error("non-final byte shown with no bytes left");

	a_no_pop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !q_ready)
		else $error("queue popped mid item");

endmodule

### tb/tb_cbor_scalar_head_encoder_core.sv
// Testbench for the CBOR scalar head encoder: directed and random items, byte-level checks.
`timescale 1ns / 100ps

module tb_cbor_scalar_head_encoder_core;
	import cshe_pkg::*;

	localparam logic [7:0] HALF_LO     = 8'h00;
	localparam int IDLE_PCT       = 13;
	localparam int RANDOM_ITEMS   = 400;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int TAIL_CYCLES    = 20;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} enc_byte_t;

	logic clk;
	logic arst_n;
	bit   quiet;
	int   mismatches;
	int   stall_cycles;

	enc_byte_t pending_bytes[$];

	cshe_in_if  in_ch();
	cshe_out_if out_ch();

	cbor_scalar_head_encoder_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// expected encoding, one entry per output word
	function automatic void push_byte(input logic [7:0] b);
		pending_bytes.push_back('{data: b, last: 1'b0});
	endfunction

	function automatic void push_head(input logic [2:0] major, input logic [63:0] arg);
		int         nbytes;
		logic [4:0] ai;
		if (arg < 64'd24) begin
			push_byte({major, arg[4:0]});
			return;
		end
		if (arg <= 64'hFF) begin
			ai = AI_1BYTE;
			nbytes = 1;
		end else if (arg <= 64'hFFFF) begin
			ai = AI_2BYTE;
			nbytes = 2;
		end else if (arg <= 64'hFFFF_FFFF) begin
			ai = AI_4BYTE;
			nbytes = 4;
		end else begin
			ai = AI_8BYTE;
			nbytes = 8;
		end
		push_byte({major, ai});
		for (int i = nbytes - 1; i >= 0; i--)
			push_byte(arg[8*i +: 8]);
	endfunction

	function automatic void predict_encoding(input logic [2:0] mode, input logic [2:0] major,
			input logic [63:0] value);
		int first;
		first = pending_bytes.size();
		case (mode)
			MODE_HEAD: push_head(major, value);
			MODE_SINT: begin
				if (!value[63])
					push_head(MAJOR_UINT, value);
				else
					push_head(MAJOR_NINT, ~value);
			end
			MODE_F64: begin
				if (value[62:52] == 11'h7FF) begin
					push_byte(BYTE_HALF);
					if (value[51:0] != 52'd0)
						push_byte(HALF_NAN_HI);
					else if (value[63])
						push_byte(HALF_NINF_HI);
					else
						push_byte(HALF_PINF_HI);
					push_byte(HALF_LO);
				end else begin
					push_byte(BYTE_DOUBLE);
					for (int i = 7; i >= 0; i--)
						push_byte(value[8*i +: 8]);
				end
			end
			MODE_BOOL: push_byte(value[0] ? BYTE_TRUE : BYTE_FALSE);
			MODE_NULL: push_byte(BYTE_NULL);
			MODE_UNDEF: push_byte(BYTE_UNDEF);
			MODE_SIMPLE: begin
				if (value[7:0] < SIMPLE_LIMIT) begin
					push_byte({MAJOR_SIMPLE, value[4:0]});
				end else begin
					push_byte(BYTE_SIMPLE8);
					push_byte(value[7:0]);
				end
			end
			default: ;
		endcase
		if (pending_bytes.size() > first)
			pending_bytes[pending_bytes.size() - 1].last = 1'b1;
	endfunction

	// called right after a rising edge; returns right after the edge that took the word
	task automatic send_word(input logic [2:0] mode, input logic [2:0] major,
			input logic [63:0] value);
		logic took;
		while (!quiet && $urandom_range(99) < IDLE_PCT) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid      <= 1'b1;
		in_ch.mode       <= mode;
		in_ch.major_type <= major;
		in_ch.value      <= value;
		took = 1'b0;
		while (!took) begin
			@(negedge clk);
			took = in_ch.ready;
			@(posedge clk);
		end
		predict_encoding(mode, major, value);
	endtask

	// argument spread over every size class
	function automatic logic [63:0] rand_arg();
		logic [63:0] v;
		v = {$urandom, $urandom};
		case ($urandom_range(5))
			0: v = 64'(v[4:0]) % 64'd24;
			1: v = {56'd0, v[7:0]};
			2: v = {48'd0, v[15:0]};
			3: v = {32'd0, v[31:0]};
			default: ;
		endcase
		return v;
	endfunction

	task automatic test_head_args();
		send_word(MODE_HEAD, 3'd0, 64'd23);
		send_word(MODE_HEAD, 3'd1, 64'd24);
		send_word(MODE_HEAD, 3'd2, 64'hFF);
		send_word(MODE_HEAD, 3'd3, 64'h100);
		send_word(MODE_HEAD, 3'd4, 64'hFFFF);
		send_word(MODE_HEAD, 3'd5, 64'h1_0000);
		send_word(MODE_HEAD, 3'd6, 64'hFFFF_FFFF);
		send_word(MODE_HEAD, 3'd7, 64'hFFFF_FFFF_FFFF_FFFF);
	endtask

	task automatic test_signed_ints();
		send_word(MODE_SINT, 3'd7, 64'h7FFF_FFFF_FFFF_FFFF);
		send_word(MODE_SINT, 3'd0, 64'hFFFF_FFFF_FFFF_FFFF);
		send_word(MODE_SINT, 3'd5, -64'sd25);
		send_word(MODE_SINT, 3'd2, 64'h8000_0000_0000_0000);
	endtask

	task automatic test_float_classes();
		send_word(MODE_F64, 3'd0, 64'h7FF8_0000_0000_0000);
		send_word(MODE_F64, 3'd0, 64'h7FF0_0000_0000_0000);
		send_word(MODE_F64, 3'd0, 64'hFFF0_0000_0000_0000);
		send_word(MODE_F64, 3'd0, 64'h8000_0000_0000_0001);
	endtask

	task automatic test_fixed_items();
		send_word(MODE_BOOL, 3'd3, 64'hFFFF_FFFF_FFFF_FFFE);
		send_word(MODE_BOOL, 3'd0, 64'd1);
		send_word(MODE_NULL, 3'd7, 64'hDEAD_BEEF_0123_4567);
		send_word(MODE_UNDEF, 3'd1, 64'd0);
		send_word(MODE_SIMPLE, 3'd0, 64'hFF00_0000_0000_0013);
		send_word(MODE_SIMPLE, 3'd0, 64'd20);
		send_word(MODE_SIMPLE, 3'd0, 64'hFF);
		// reserved mode: taken, nothing comes out
		send_word(MODE_RSVD, 3'd0, 64'hFFFF_FFFF_FFFF_FFFF);
	endtask

	task automatic test_random_items();
		int          sent;
		logic [2:0]  mode;
		logic [63:0] value;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			quiet = (sent >= 150 && sent < 250);
			mode = ($urandom_range(99) < 3) ? MODE_RSVD : 3'($urandom_range(6));
			value = {$urandom, $urandom};
			case (mode)
				MODE_HEAD: value = rand_arg();
				MODE_SINT: begin
					value = rand_arg();
					if ($urandom_range(1))
						value = ~value;
				end
				MODE_F64: begin
					case ($urandom_range(4))
						0: value[62:52] = 11'h7FF;
						1: begin
							value[62:52] = 11'h7FF;
							value[51:0] = 52'd0;
						end
						2: value[62:52] = 11'h000;
						default: ;
					endcase
				end
				MODE_SIMPLE: if ($urandom_range(1)) value[7:0] = 8'($urandom_range(31));
				default: ;
			endcase
			send_word(mode, 3'($urandom), value);
			if (mode != MODE_RSVD)
				sent++;
		end
		quiet = 1'b0;
	endtask

	always @(posedge clk)
		out_ch.ready <= quiet || ($urandom_range(99) >= IDLE_PCT);

	// output check and watchdog; words are sampled between edges
	always @(negedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_bytes.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected word: byte %h last %b", $time,
					out_ch.out_byte, out_ch.last);
			end else begin
				if (out_ch.out_byte !== pending_bytes[0].data) begin
					mismatches++;
					$display("%0t: out_byte expected %h actual %h", $time,
						pending_bytes[0].data, out_ch.out_byte);
				end
				if (out_ch.last !== pending_bytes[0].last) begin
					mismatches++;
					$display("%0t: last expected %b actual %b", $time,
						pending_bytes[0].last, out_ch.last);
				end
				void'(pending_bytes.pop_front());
			end
		end
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		quiet = 1'b0;
		mismatches = 0;
		stall_cycles = 0;
		in_ch.valid = 1'b0;
		in_ch.mode = MODE_HEAD;
		in_ch.major_type = 3'd0;
		in_ch.value = 64'd0;
		out_ch.ready = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_head_args();
		test_signed_ints();
		test_float_classes();
		test_fixed_items();
		test_random_items();

		in_ch.valid <= 1'b0;
		while (pending_bytes.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

### sim.f
src/cshe_pkg.sv
src/cshe_in_if.sv
src/cshe_out_if.sv
src/cshe_front.sv
src/cshe_queue.sv
src/cshe_back.sv
src/cbor_scalar_head_encoder_core.sv
tb/tb_cbor_scalar_head_encoder_core.sv
